// ===== design/mesic_pkg.sv =====
package mesic_pkg;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_t;

  typedef enum logic [2:0] {
    OP_PR_RD    = 3'd0,
    OP_PR_WR    = 3'd1,
    OP_BUS_RD   = 3'd2,
    OP_BUS_RDX  = 3'd3,
    OP_BUS_UPGR = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_RD   = 2'd1,
    BUS_RDX  = 2'd2,
    BUS_UPGR = 2'd3
  } bus_t;

  typedef enum logic [1:0] {
    CTL_CLEAR,
    CTL_IDLE,
    CTL_LOOKUP
  } ctl_state_t;

  typedef struct packed {
    logic  hit;
    bus_t  bus_request;
    logic  line_fill;
    logic  write_back;
    logic  held_copy;
    logic  intervened;
    logic  invalidated;
    mesi_t prior_state;
    mesi_t next_state;
  } result_t;

endpackage

// ===== design/mesic_state_ram.sv =====
module mesic_state_ram #(
  parameter int IDX_W = 10
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  output mesic_pkg::mesi_t     rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  mesic_pkg::mesi_t     wr_data
);

  localparam int DEPTH = 2 ** IDX_W;

  mesic_pkg::mesi_t mem [DEPTH];
  mesic_pkg::mesi_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // hold the read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/mesic_next.sv =====
module mesic_next (
  input  logic [2:0]         op,
  input  mesic_pkg::mesi_t   prior,
  input  logic               shared,
  output mesic_pkg::result_t res
);

  always_comb begin
    res             = '0;
    res.bus_request = mesic_pkg::BUS_NONE;
    res.prior_state = prior;
    res.next_state  = prior;
    case (mesic_pkg::op_t'(op))
      mesic_pkg::OP_PR_RD: begin
        if (prior != mesic_pkg::ST_I) begin
          res.hit = 1'b1;
        end else begin
          res.bus_request = mesic_pkg::BUS_RD;
          res.line_fill   = 1'b1;
          res.next_state  = shared ? mesic_pkg::ST_S : mesic_pkg::ST_E;
        end
      end
      mesic_pkg::OP_PR_WR: begin
        if (prior == mesic_pkg::ST_I) begin
          res.bus_request = mesic_pkg::BUS_RDX;
          res.line_fill   = 1'b1;
        end else begin
          res.hit = 1'b1;
          if (prior == mesic_pkg::ST_S) begin
            res.bus_request = mesic_pkg::BUS_UPGR;
          end
        end
        res.next_state = mesic_pkg::ST_M;
      end
      mesic_pkg::OP_BUS_RD: begin
        if (prior != mesic_pkg::ST_I) begin
          res.held_copy  = 1'b1;
          res.write_back = (prior == mesic_pkg::ST_M);
          res.intervened = (prior == mesic_pkg::ST_M);
          res.next_state = mesic_pkg::ST_S;
        end
      end
      mesic_pkg::OP_BUS_RDX, mesic_pkg::OP_BUS_UPGR: begin
        // upgrade seen on any valid line, Modified too: treat as read-exclusive
        if (prior != mesic_pkg::ST_I) begin
          res.held_copy   = 1'b1;
          res.write_back  = (prior == mesic_pkg::ST_M);
          res.intervened  = (prior == mesic_pkg::ST_M);
          res.invalidated = 1'b1;
          res.next_state  = mesic_pkg::ST_I;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/mesi_coherence_controller_core.sv =====
// MESI line-state controller.
// Input channel (in_valid/in_ready) carries one coherence event per transaction:
// processor read or write, or a snooped BusRd, BusRdX or BusUpgr, with the byte
// address and the shared response for read misses. The output channel
// (out_valid/out_ready) returns one result transaction per event: hit, bus
// request, fill, write-back, held-copy, intervention and invalidation flags,
// and the line state before and after the event.
// Each event reads the line state from a synchronous-read RAM, updates it and
// writes it back. The RAM read is registered on acceptance and the lookup state
// loads the result; a new event is taken only once back in the idle state.
// The output register parts the two channels: the next event is taken while a
// result waits. If a result is still held when the next one is ready, the
// lookup holds and writes nothing until the output register frees.
// After reset the state RAM is swept to Invalid, one line per cycle, over
// 2**(ADDR_BITS - log2(LINE_BYTES)) lines (1024 with the defaults); in_ready
// stays low during the sweep. in_other_copy is ignored.
module mesi_coherence_controller_core #(
  parameter int ADDR_BITS  = 16,
  parameter int LINE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_address,
  input  logic        in_other_copy,
  input  logic        in_shared_seen,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [1:0]  out_bus_request,
  output logic        out_line_fill,
  output logic        out_write_back,
  output logic        out_held_copy,
  output logic        out_intervened,
  output logic        out_invalidated,
  output logic [1:0]  out_prior_state,
  output logic [1:0]  out_next_state
);

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int IDX_W = ADDR_BITS - OFF_W;

  mesic_pkg::ctl_state_t state_r, state_nxt;

  logic [ADDR_BITS-1:0] addr_ext;
  logic [IDX_W-1:0]     in_idx;
  logic [IDX_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]     idx_r;
  logic [2:0]           op_r;
  logic                 shared_r;
  logic                 out_valid_r, out_valid_nxt;
  mesic_pkg::result_t   res_r;
  mesic_pkg::result_t   res;
  mesic_pkg::mesi_t     rd_data;
  mesic_pkg::mesi_t     wr_data;
  logic [IDX_W-1:0]     wr_idx;
  logic                 wr_en;
  logic                 accept;
  logic                 out_free;
  logic                 load;
  logic                 clearing;

  assign addr_ext = ADDR_BITS'(in_address);
  assign in_idx   = addr_ext[ADDR_BITS-1:OFF_W];
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mesic_pkg::CTL_CLEAR: begin
        if (clr_idx_r == {IDX_W{1'b1}}) begin
          state_nxt = mesic_pkg::CTL_IDLE;
        end
      end
      mesic_pkg::CTL_IDLE: begin
        if (in_valid) begin
          state_nxt = mesic_pkg::CTL_LOOKUP;
        end
      end
      mesic_pkg::CTL_LOOKUP: begin
        if (out_free) begin
          state_nxt = mesic_pkg::CTL_IDLE;
        end
      end
      default: begin
        state_nxt = mesic_pkg::CTL_CLEAR;
      end
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    clearing = 1'b0;
    case (state_r)
      mesic_pkg::CTL_CLEAR:  clearing = 1'b1;
      mesic_pkg::CTL_IDLE:   in_ready = 1'b1;
      mesic_pkg::CTL_LOOKUP: load     = out_free;
      default: begin
      end
    endcase
  end

  assign accept      = in_valid && in_ready;
  assign clr_idx_nxt = clr_idx_r + 1'b1;

  assign wr_en   = clearing || load;
  assign wr_idx  = clearing ? clr_idx_r : idx_r;
  assign wr_data = clearing ? mesic_pkg::ST_I : res.next_state;

  mesic_state_ram #(
    .IDX_W(IDX_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_idx  (in_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

  mesic_next u_next (
    .op     (op_r),
    .prior  (rd_data),
    .shared (shared_r),
    .res    (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mesic_pkg::CTL_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clearing) begin
        clr_idx_r <= clr_idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_opcode;
      idx_r    <= in_idx;
      shared_r <= in_shared_seen;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = res_r.hit;
  assign out_bus_request = res_r.bus_request;
  assign out_line_fill   = res_r.line_fill;
  assign out_write_back  = res_r.write_back;
  assign out_held_copy   = res_r.held_copy;
  assign out_intervened  = res_r.intervened;
  assign out_invalidated = res_r.invalidated;
  assign out_prior_state = res_r.prior_state;
  assign out_next_state  = res_r.next_state;

endmodule
